// ===== src/aes_ctr_keystream_xor_unit_defines.svh =====
// Assertion macros shared by the CTR keystream unit.
// Included by modules that carry concurrent checks; needs no package.
`ifndef AES_CTR_KEYSTREAM_XOR_UNIT_DEFINES_SVH
`define AES_CTR_KEYSTREAM_XOR_UNIT_DEFINES_SVH

// Generic check with explicit clock and reset
`define AESC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on the block's own clock and reset
`define AESC_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== src/aesc_pkg.sv =====
// Types, constants and AES helper functions for the CTR keystream unit.
// No dependencies; used by the AES core, the top level, the checker and the testbench.
package aesc_pkg;

   localparam int BLOCK_W    = 128;
   localparam int AES_ROUNDS = 10;
   localparam int RND_W      = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // Register indexes (paddr[4:3])
   localparam logic [1:0] REG_KEY_LO    = 2'd0;
   localparam logic [1:0] REG_KEY_HI    = 2'd1;
   localparam logic [1:0] REG_NONCE     = 2'd2;
   localparam logic [1:0] REG_START_CTR = 2'd3;

   localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(AES_ROUNDS);

   typedef struct packed {
      logic expand_start;
      logic enc_start;
      logic abort;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic expanding;
      logic done;
   } core_sts_type;

   localparam logic [7:0] SBOX_TABLE [0:255] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] sbox(input logic [7:0] b);
      return SBOX_TABLE[b];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Round constant for round key row 1..10
   function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1:    v = 8'h01;
         4'd2:    v = 8'h02;
         4'd3:    v = 8'h04;
         4'd4:    v = 8'h08;
         4'd5:    v = 8'h10;
         4'd6:    v = 8'h20;
         4'd7:    v = 8'h40;
         4'd8:    v = 8'h80;
         4'd9:    v = 8'h1b;
         4'd10:   v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // One round key row from the previous one (row = w0..w3, w0 on top)
   function automatic logic [BLOCK_W-1:0] next_round_key(input logic [BLOCK_W-1:0] p,
                                                         input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] n0;
      logic [31:0] n1;
      logic [31:0] n2;
      logic [31:0] n3;
      t  = {sbox(p[23:16]), sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])} ^ {rc, 24'h000000};
      n0 = p[127:96] ^ t;
      n1 = p[95:64] ^ n0;
      n2 = p[63:32] ^ n1;
      n3 = p[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // SubBytes, ShiftRows and (unless final) MixColumns; byte i at [127-8i -: 8]
   function automatic logic [BLOCK_W-1:0] aes_round(input logic [BLOCK_W-1:0] s,
                                                    input logic final_rnd);
      logic [7:0] sb [16];
      logic [7:0] sr [16];
      logic [7:0] a0;
      logic [7:0] a1;
      logic [7:0] a2;
      logic [7:0] a3;
      logic [7:0] all;
      logic [BLOCK_W-1:0] res;
      for (int i = 0; i < 16; i++) sb[i] = sbox(s[127-8*i -: 8]);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) sr[r+4*c] = sb[r+4*((c+r)%4)];
      for (int c = 0; c < 4; c++) begin
         a0  = sr[4*c];
         a1  = sr[4*c+1];
         a2  = sr[4*c+2];
         a3  = sr[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (!final_rnd) begin
            a0 = sr[4*c]   ^ all ^ xtime(sr[4*c]   ^ sr[4*c+1]);
            a1 = sr[4*c+1] ^ all ^ xtime(sr[4*c+1] ^ sr[4*c+2]);
            a2 = sr[4*c+2] ^ all ^ xtime(sr[4*c+2] ^ sr[4*c+3]);
            a3 = sr[4*c+3] ^ all ^ xtime(sr[4*c+3] ^ sr[4*c]);
         end
         res[127-32*c -: 32] = {a0, a1, a2, a3};
      end
      return res;
   endfunction

endpackage

// ===== src/aesc_stream_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on nothing but plain logic types.
interface aesc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_in;
   logic       last_byte;
   modport source (output valid, output data_in, output last_byte, input ready);
   modport sink   (input valid, input data_in, input last_byte, output ready);
endinterface

interface aesc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   modport source (output valid, output data_out, input ready);
   modport sink   (input valid, input data_out, output ready);
endinterface

// ===== src/aesc_core.sv =====
// Iterative AES-128 encryption core with its round key memory.
// Depends on aesc_pkg (round functions, control and status structs).
module aesc_core (
   input  logic                         clock,
   input  logic                         reset,
   input  aesc_pkg::core_ctl_type       ctl,
   input  logic [aesc_pkg::BLOCK_W-1:0] key_block,
   input  logic [aesc_pkg::BLOCK_W-1:0] pt_block,
   output aesc_pkg::core_sts_type       sts,
   output logic [aesc_pkg::BLOCK_W-1:0] ct_block
);

   // Round key memory: one 128-bit row per round, plus row 0 for the initial key add
   logic [aesc_pkg::BLOCK_W-1:0] rk_mem [0:aesc_pkg::AES_ROUNDS];

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic                         exp_ff, exp_in;
   logic [aesc_pkg::RND_W-1:0]   exp_idx_ff, exp_idx_in;
   logic [aesc_pkg::BLOCK_W-1:0] exp_row_ff, exp_row_in;
   logic [aesc_pkg::RND_W-1:0]   rnd_ff, rnd_in;
   logic [aesc_pkg::BLOCK_W-1:0] state_ff, state_in;
   logic [aesc_pkg::BLOCK_W-1:0] rk_q_ff;
   logic [aesc_pkg::BLOCK_W-1:0] next_row;
   logic                         rd_en;
   logic [aesc_pkg::RND_W-1:0]   rd_addr;
   logic                         last_step;

   assign next_row  = aesc_pkg::next_round_key(exp_row_ff, aesc_pkg::rcon(exp_idx_ff));
   assign last_step = busy_ff && (rnd_ff == aesc_pkg::LAST_ROUND);

   // Key schedule sweep: row 0 on start, rows 1..10 one per cycle
   always_comb begin
      exp_in     = exp_ff;
      exp_idx_in = exp_idx_ff;
      exp_row_in = exp_row_ff;
      if (ctl.expand_start) begin
         exp_in     = 1'b1;
         exp_idx_in = aesc_pkg::RND_W'(1);
         exp_row_in = key_block;
      end else if (exp_ff) begin
         exp_row_in = next_row;
         exp_idx_in = exp_idx_ff + aesc_pkg::RND_W'(1);
         if (exp_idx_ff == aesc_pkg::LAST_ROUND) exp_in = 1'b0;
      end
   end

   // Round key registered from memory in the cycle before the round that uses it
   assign rd_en   = ctl.enc_start || (busy_ff && !last_step);
   assign rd_addr = ctl.enc_start ? '0 : rnd_ff + aesc_pkg::RND_W'(1);

   always_ff @(posedge clock) begin
      if (ctl.expand_start) begin
         rk_mem[0] <= key_block;
      end else if (exp_ff) begin
         rk_mem[exp_idx_ff] <= next_row;
      end
      if (rd_en) begin
         rk_q_ff <= rk_mem[rd_addr];
      end
   end

   // Round sequencing: initial key add, then ten rounds
   always_comb begin
      busy_in  = busy_ff;
      rnd_in   = rnd_ff;
      state_in = state_ff;
      done_in  = last_step && !ctl.abort;
      if (ctl.abort) begin
         busy_in = 1'b0;
      end else if (ctl.enc_start) begin
         busy_in  = 1'b1;
         rnd_in   = '0;
         state_in = pt_block;
      end else if (busy_ff) begin
         state_in = (rnd_ff == '0) ? (state_ff ^ rk_q_ff)
                  : (aesc_pkg::aes_round(state_ff, last_step) ^ rk_q_ff);
         rnd_in   = rnd_ff + aesc_pkg::RND_W'(1);
         if (last_step) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         exp_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         exp_ff  <= exp_in;
      end
      exp_idx_ff <= exp_idx_in;
      exp_row_ff <= exp_row_in;
      rnd_ff     <= rnd_in;
      state_ff   <= state_in;
   end

   assign sts.busy      = busy_ff;
   assign sts.expanding = exp_ff;
   assign sts.done      = done_ff;
   assign ct_block      = state_ff;

endmodule

// ===== src/aes_ctr_keystream_xor_unit.sv =====
// AES-128 counter mode byte unit: each accepted byte leaves XORed with its keystream byte,
// one item per cycle sustained while the output takes items and no register write holds input.
// Keystream blocks are made ahead of the bytes by an iterative AES core (one round per
// cycle, round keys read from a round key memory) into two block slots, so a running
// message is paced by the handshakes only. The first byte of a message waits after the
// previous last byte for its block. A key write starts a key schedule sweep first, so a
// byte that needs a fresh block then also waits for the sweep. A key or nonce write inside a
// message keeps the block in use and remakes the following ones; a start_counter write
// inside a message applies to the next message. Input is held off during a register write.
// Depends on aesc_pkg, aesc_stream_if.sv, aesc_core and the defines header.
`include "aes_ctr_keystream_xor_unit_defines.svh"

module aes_ctr_keystream_xor_unit (
   input  logic                            clock,
   input  logic                            reset,
   aesc_req_if.sink                        req,
   aesc_rsp_if.source                      rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [aesc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [aesc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [aesc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic [aesc_pkg::CSR_DATA_W-1:0] key_lo_ff, key_hi_ff, nonce_ff, start_ctr_ff;
   logic [63:0]                     gen_ctr_ff, gen_ctr_in;
   logic [63:0]                     cur_ctr_ff, cur_ctr_in;
   logic                            msg_open_ff, msg_open_in;
   logic                            exp_req_ff, exp_req_in;
   logic [aesc_pkg::BLOCK_W-1:0]    ks_ff [2];
   logic [1:0]                      ks_valid_ff, ks_valid_in;
   logic                            rd_sel_ff, rd_sel_in;
   logic                            wr_sel_ff, wr_sel_in;
   logic [3:0]                      pos_ff, pos_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      rsp_data_ff;

   logic                            cfg_wr;
   logic [1:0]                      cfg_idx;
   logic                            req_fire;
   logic                            last_flush;
   logic                            cfg_restart;
   logic                            keep_cur;
   logic                            flush;
   logic                            fill;
   logic [63:0]                     new_start;
   logic [aesc_pkg::BLOCK_W-1:0]    key_block, pt_block, ct_block, cur_blk;
   logic [7:0]                      ks_byte;
   aesc_pkg::core_ctl_type          core_ctl;
   aesc_pkg::core_sts_type          core_sts;

   // Configuration port
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = paddr[4:3];

   always_comb begin
      unique case (cfg_idx)
         aesc_pkg::REG_KEY_LO:    prdata = key_lo_ff;
         aesc_pkg::REG_KEY_HI:    prdata = key_hi_ff;
         aesc_pkg::REG_NONCE:     prdata = nonce_ff;
         aesc_pkg::REG_START_CTR: prdata = start_ctr_ff;
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff    <= '0;
         key_hi_ff    <= '0;
         nonce_ff     <= '0;
         start_ctr_ff <= '0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            aesc_pkg::REG_KEY_LO:    key_lo_ff    <= pwdata;
            aesc_pkg::REG_KEY_HI:    key_hi_ff    <= pwdata;
            aesc_pkg::REG_NONCE:     nonce_ff     <= pwdata;
            aesc_pkg::REG_START_CTR: start_ctr_ff <= pwdata;
            default:                 ;
         endcase
      end
   end

   // Key and counter blocks, byte i at [127-8i -: 8]
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         key_block[127-8*i -: 8]      = key_lo_ff[8*i +: 8];
         key_block[127-8*(i+8) -: 8]  = key_hi_ff[8*i +: 8];
         pt_block[127-8*i -: 8]       = nonce_ff[8*i +: 8];
         pt_block[127-8*(i+8) -: 8]   = gen_ctr_ff[8*i +: 8];
      end
   end

   // Item handshakes; a last byte drops all prefetched blocks, a register write drops
   // the blocks not yet in use (start_counter inside a message drops nothing)
   assign req_fire    = req.valid && req.ready;
   assign req.ready   = ks_valid_ff[rd_sel_ff] && (!rsp_valid_ff || rsp.ready) && !cfg_wr;
   assign last_flush  = req_fire && req.last_byte;
   assign cfg_restart = cfg_wr && ((cfg_idx != aesc_pkg::REG_START_CTR) || !msg_open_ff);
   assign keep_cur    = cfg_restart && msg_open_ff && (pos_ff != 4'd0);
   assign flush       = last_flush || cfg_restart;
   assign fill        = core_sts.done && !flush;
   assign new_start   = (cfg_wr && (cfg_idx == aesc_pkg::REG_START_CTR)) ? pwdata
                      : start_ctr_ff;
   assign msg_open_in = req_fire ? !req.last_byte : msg_open_ff;

   assign exp_req_in = cfg_wr && ((cfg_idx == aesc_pkg::REG_KEY_LO) ||
                                  (cfg_idx == aesc_pkg::REG_KEY_HI));

   assign core_ctl.expand_start = exp_req_ff;
   assign core_ctl.abort        = flush;
   assign core_ctl.enc_start    = !core_sts.busy && !core_sts.done && !core_sts.expanding &&
                                  !exp_req_ff && !ks_valid_ff[wr_sel_ff] && !flush;

   aesc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (core_ctl),
      .key_block (key_block),
      .pt_block  (pt_block),
      .sts       (core_sts),
      .ct_block  (ct_block)
   );

   // Keystream byte at the current position
   assign cur_blk = ks_ff[rd_sel_ff];
   assign ks_byte = cur_blk[{~pos_ff, 3'b000} +: 8];

   // Slot, counter and position bookkeeping; cur_ctr is the counter of the read slot
   always_comb begin
      ks_valid_in = ks_valid_ff;
      rd_sel_in   = rd_sel_ff;
      wr_sel_in   = wr_sel_ff;
      pos_in      = pos_ff;
      gen_ctr_in  = gen_ctr_ff;
      cur_ctr_in  = cur_ctr_ff;
      if (core_ctl.enc_start) gen_ctr_in = gen_ctr_ff + 64'd1;
      if (fill) begin
         ks_valid_in[wr_sel_ff] = 1'b1;
         wr_sel_in              = ~wr_sel_ff;
      end
      if (req_fire) begin
         pos_in = pos_ff + 4'd1;
         if (pos_ff == 4'hf) begin
            ks_valid_in[rd_sel_ff] = 1'b0;
            rd_sel_in              = ~rd_sel_ff;
            cur_ctr_in             = cur_ctr_ff + 64'd1;
         end
      end
      // next message starts from start_counter
      if (last_flush || (cfg_restart && !msg_open_ff)) begin
         cur_ctr_in = new_start;
         pos_in     = '0;
      end
      if (flush) begin
         ks_valid_in = '0;
         wr_sel_in   = rd_sel_in;
         gen_ctr_in  = cur_ctr_in;
         // block in use stays, the following ones are remade
         if (keep_cur) begin
            ks_valid_in[rd_sel_ff] = ks_valid_ff[rd_sel_ff];
            wr_sel_in              = ~rd_sel_ff;
            gen_ctr_in             = cur_ctr_ff + 64'd1;
         end
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_valid_ff  <= '0;
         rd_sel_ff    <= 1'b0;
         wr_sel_ff    <= 1'b0;
         pos_ff       <= '0;
         gen_ctr_ff   <= '0;
         cur_ctr_ff   <= '0;
         msg_open_ff  <= 1'b0;
         exp_req_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         ks_valid_ff  <= ks_valid_in;
         rd_sel_ff    <= rd_sel_in;
         wr_sel_ff    <= wr_sel_in;
         pos_ff       <= pos_in;
         gen_ctr_ff   <= gen_ctr_in;
         cur_ctr_ff   <= cur_ctr_in;
         msg_open_ff  <= msg_open_in;
         exp_req_ff   <= exp_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fill) ks_ff[wr_sel_ff] <= ct_block;
      if (req_fire) rsp_data_ff <= req.data_in ^ ks_byte;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.data_out = rsp_data_ff;

   // Checks
   `AESC_ASSERT_CLK(a_fill_free_slot, fill |-> !ks_valid_ff[wr_sel_ff], "fill over a live slot")
   `AESC_ASSERT_CLK(a_last_clears, (req_fire && req.last_byte) |=> (ks_valid_ff == 2'b00), "slots kept after last byte")
   `AESC_ASSERT_CLK(a_no_enc_in_expand, !(core_ctl.enc_start && (core_sts.expanding || exp_req_ff)), "encrypt during key schedule")
   `AESC_ASSERT(a_mid_block_valid, clock, reset, (pos_ff != 4'd0) |-> ks_valid_ff[rd_sel_ff], "partial block without keystream")

endmodule

// ===== dv/aes_ctr_keystream_xor_unit_checker.sv =====
`timescale 1ns / 1ps
// Checker for the AES-128 CTR byte unit: watches the register port and both channels.
// Predicts every output byte and compares; depends on aesc_pkg and aesc_stream_if.sv.
module aes_ctr_keystream_xor_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   aesc_req_if                             req,
   aesc_rsp_if                             rsp,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [aesc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [aesc_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                            pready,
   output int                              fail_count,
   output int                              pending_bytes
);

   // shadow of the register file
   logic [63:0] key_lo, key_hi, nonce, start_ctr;
   // shadow of the running message
   logic [63:0]  blk_ctr;
   logic [3:0]   byte_pos;
   logic         msg_open;
   logic [127:0] pad;
   logic [7:0]   expected_bytes[$];

   function automatic logic [7:0] gf_double(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // AES-128 encryption of the counter block; byte i of the result at [8i +: 8]
   function automatic logic [127:0] ctr_pad(input logic [63:0] klo, input logic [63:0] khi,
                                            input logic [63:0] nv, input logic [63:0] ctr);
      logic [7:0]   k[16];
      logic [7:0]   s[16];
      logic [7:0]   t[16];
      logic [31:0]  w[44];
      logic [31:0]  tw;
      logic [7:0]   rc, a0, a1, a2, a3, all;
      logic [127:0] r;
      for (int i = 0; i < 8; i++) begin
         k[i]     = klo[8*i +: 8];
         k[i + 8] = khi[8*i +: 8];
         s[i]     = nv[8*i +: 8];
         s[i + 8] = ctr[8*i +: 8];
      end
      // key schedule
      for (int i = 0; i < 4; i++) w[i] = {k[4*i], k[4*i+1], k[4*i+2], k[4*i+3]};
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         tw = w[i-1];
         if (i % 4 == 0) begin
            tw = {tw[23:0], tw[31:24]};
            tw = {aesc_pkg::SBOX_TABLE[tw[31:24]], aesc_pkg::SBOX_TABLE[tw[23:16]],
                  aesc_pkg::SBOX_TABLE[tw[15:8]], aesc_pkg::SBOX_TABLE[tw[7:0]]}
                 ^ {rc, 24'h000000};
            rc = gf_double(rc);
         end
         w[i] = w[i-4] ^ tw;
      end
      for (int c = 0; c < 4; c++)
         for (int q = 0; q < 4; q++) s[q+4*c] ^= w[c][31-8*q -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int i = 0; i < 16; i++) s[i] = aesc_pkg::SBOX_TABLE[s[i]];
         for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++) t[q+4*c] = s[q+4*((c+q)%4)];
         s = t;
         if (rnd != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0  = s[4*c];
               a1  = s[4*c+1];
               a2  = s[4*c+2];
               a3  = s[4*c+3];
               all = a0 ^ a1 ^ a2 ^ a3;
               s[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
               s[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
               s[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
               s[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
            end
         end
         for (int c = 0; c < 4; c++)
            for (int q = 0; q < 4; q++) s[q+4*c] ^= w[4*rnd+c][31-8*q -: 8];
      end
      for (int i = 0; i < 16; i++) r[8*i +: 8] = s[i];
      return r;
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         key_lo        = '0;
         key_hi        = '0;
         nonce         = '0;
         start_ctr     = '0;
         blk_ctr       = '0;
         byte_pos      = '0;
         msg_open      = 1'b0;
         fail_count    = 0;
         expected_bytes.delete();
         pending_bytes = 0;
      end else begin
         // register writes
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:3])
               aesc_pkg::REG_KEY_LO:    key_lo    = pwdata;
               aesc_pkg::REG_KEY_HI:    key_hi    = pwdata;
               aesc_pkg::REG_NONCE:     nonce     = pwdata;
               aesc_pkg::REG_START_CTR: start_ctr = pwdata;
               default: ;
            endcase
         end
         // predict each accepted byte
         if (req.valid && req.ready) begin
            if (!msg_open) begin
               blk_ctr  = start_ctr;
               byte_pos = '0;
               msg_open = 1'b1;
            end
            if (byte_pos == 0) begin
               pad     = ctr_pad(key_lo, key_hi, nonce, blk_ctr);
               blk_ctr = blk_ctr + 64'd1;
            end
            expected_bytes.push_back(req.data_in ^ pad[8*byte_pos +: 8]);
            byte_pos = byte_pos + 4'd1;
            if (req.last_byte) begin
               msg_open = 1'b0;
               byte_pos = '0;
            end
         end
         // compare each accepted output byte
         if (rsp.valid && rsp.ready) begin
            if (expected_bytes.size() == 0) begin
               $display("%0t: unexpected output byte, expected none, actual %02h",
                        $time, rsp.data_out);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp.data_out !== want) begin
                  $display("%0t: data_out mismatch, expected %02h, actual %02h",
                           $time, want, rsp.data_out);
                  fail_count++;
               end
            end
         end
         pending_bytes = expected_bytes.size();
      end
   end
endmodule

// ===== dv/aes_ctr_keystream_xor_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the AES-128 CTR byte unit: clock, reset, stimulus and verdict.
// Depends on aesc_pkg, aesc_stream_if.sv, the unit and its checker.
module aes_ctr_keystream_xor_unit_tb;

   localparam int IDLE_LIMIT = 3000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [aesc_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [aesc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [aesc_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;
   logic                            calm = 1'b0;
   int                              fail_count, pending_bytes, idle_cycles;

   aesc_req_if req ();
   aesc_rsp_if rsp ();

   initial begin
      req.valid     = 1'b0;
      req.data_in   = '0;
      req.last_byte = 1'b0;
      rsp.ready     = 1'b0;
   end

   always #2 clock = ~clock;

   aes_ctr_keystream_xor_unit DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   aes_ctr_keystream_xor_unit_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending_bytes(pending_bytes)
   );

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // output side: random stall before each item
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("aes_ctr_keystream_xor_unit_tb failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // one input item; valid stays high across back-to-back items
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.data_in   <= b;
      req.last_byte <= last;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
   endtask

   // wait for all outputs, then let the keystream prefetch settle
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_bytes != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [63:0] v);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= aesc_pkg::CSR_ADDR_W'({idx, 3'b000});
      pwdata  <= v;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [63:0] kl, kh, nv, sc;
      int sent;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset key, extreme bytes, one message crossing a block boundary
      calm = 1'b1;
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      for (int i = 0; i < 17; i++) send_byte(i[0] ? 8'hff : 8'h00, i == 16);
      drain();
      // all-ones key and nonce with the counter at its top: wraps to zero
      csr_write(aesc_pkg::REG_KEY_LO, '1);
      csr_write(aesc_pkg::REG_KEY_HI, '1);
      csr_write(aesc_pkg::REG_NONCE, '1);
      csr_write(aesc_pkg::REG_START_CTR, '1);
      for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
      send_byte(8'h5a, 1'b0);
      // register writes in the middle of a message
      drain();
      csr_write(aesc_pkg::REG_KEY_HI, rand64());
      csr_write(aesc_pkg::REG_START_CTR, 64'd7);
      for (int i = 0; i < 20; i++) send_byte(8'($urandom), i == 19);
      drain();
      csr_write(aesc_pkg::REG_NONCE, rand64());
      calm = 1'b0;

      // random phases over several register settings
      sent = 0;
      for (int ph = 0; ph < 14; ph++) begin
         send_message(20 + $urandom_range(0, 10));
         drain();
         case (ph % 4)
            0: begin kl = '0;       kh = '0;       nv = '0;       sc = '0;            end
            1: begin kl = '1;       kh = rand64(); nv = '1;       sc = 64'hffff_ffff_ffff_fffe; end
            2: begin kl = rand64(); kh = '1;       nv = rand64(); sc = rand64();      end
            default: begin kl = rand64(); kh = rand64(); nv = rand64(); sc = rand64(); end
         endcase
         csr_write(aesc_pkg::REG_KEY_LO, kl);
         csr_write(aesc_pkg::REG_KEY_HI, kh);
         csr_write(aesc_pkg::REG_NONCE, nv);
         csr_write(aesc_pkg::REG_START_CTR, sc);
         calm = (ph % 3 == 0);
         sent = 0;
         while (sent < 65) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 70)
                                              : $urandom_range(1, 34);
            send_message(len);
            sent += len;
         end
      end
      calm = 1'b0;
      drain();

      if (fail_count == 0 && pending_bytes == 0)
         $display("aes_ctr_keystream_xor_unit_tb passed");
      else
         $display("aes_ctr_keystream_xor_unit_tb failed");
      $finish;
   end
endmodule
